// ===== rtl/sample_stream_byte_packer_top_defines.svh =====
// ----------------------------------------------------------------------------
// packer assertion macros
// shared assertion forms for the byte packer checker
// ----------------------------------------------------------------------------
`ifndef SAMPLE_STREAM_BYTE_PACKER_TOP_DEFINES_SVH
`define SAMPLE_STREAM_BYTE_PACKER_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define SSBP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("packer check failed");

// next-cycle implication
`define SSBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("packer check failed");

`endif

// ===== rtl/ssbp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssbp_pkg
// types, codes and helpers for the sample byte packer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ssbp_pkg;

  typedef enum logic [2:0] {
    MODE_TEN45  = 3'd0,
    MODE_TRI32  = 3'd1,
    MODE_BYTE   = 3'd2,
    MODE_LE16   = 3'd3,
    MODE_BE16   = 3'd4,
    MODE_FLOAT  = 3'd5,
    MODE_RSVD6  = 3'd6,
    MODE_RSVD7  = 3'd7
  } mode_e;

  localparam logic CFG_PACK_MODE = 1'b0;
  localparam logic CFG_PAD_LEVEL = 1'b1;

  localparam logic [2:0]  PACK_MODE_RESET = 3'd0;
  localparam logic [9:0]  PAD_LEVEL_RESET = 10'd512;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // one job for the back end: up to five bytes and a count
  typedef struct packed {
    logic [39:0] bytes;
    logic [2:0]  count;
  } job_t;

  // float32 of a signed 17-bit value divided by 32768, exact
  function automatic logic [31:0] to_float(input logic [16:0] s);
    logic        sgn;
    logic [16:0] mag;
    logic [4:0]  msb;
    logic [22:0] man;
    logic [7:0]  ex;
    logic [39:0] sh;
    sgn = s[16];
    mag = sgn ? (~s + 17'd1) : s;
    msb = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (mag[i]) msb = 5'(i);
    end
    sh  = {23'd0, mag} << (5'd23 - msb);
    man = sh[22:0];
    ex  = 8'(8'd127 + {3'd0, msb} - 8'd15);
    if (mag == 17'd0) return 32'd0;
    return {sgn, ex, man};
  endfunction

endpackage

// ===== rtl/sample_stream_byte_packer_top.sv =====
// ----------------------------------------------------------------------------
// sample_stream_byte_packer_top
// packs samples into output bytes in one of six modes
// ----------------------------------------------------------------------------
// channel   direction  handshake                payload
// input     in         valid_i/stall_o          action_i, sample_i
// output    out        valid_o/stall_i          data_byte_o, last_o
// config    in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
// an item that completes a job is taken into the job queue at its accepting
// edge and, with the queue empty, its first byte shows the next cycle; output
// runs one byte a cycle while stall_i is low, a job giving as many bytes as
// its count (four in float mode); an item that completes no job yields none
// reset clears carried count, registers and queue
// input stalls while the two-entry queue is full; output stalls only hold it
`timescale 1ns / 1ps
module sample_stream_byte_packer_top import ssbp_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        action_i,
  input  logic [16:0] sample_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [7:0]  data_byte_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [9:0]  cfg_data_i
);

  mode_e      mode_q;
  logic [9:0] pad_q;
  logic       jv, full, empty, pop;
  job_t       jin, jout;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mode_e'(PACK_MODE_RESET);
      pad_q  <= PAD_LEVEL_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_PACK_MODE) mode_q <= mode_e'(cfg_data_i[2:0]);
      else                              pad_q  <= cfg_data_i;
    end
  end

  ssbp_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .action_i, .sample_i,
    .mode_i(mode_q), .pad_i(pad_q), .job_valid_o(jv), .job_o(jin),
    .job_full_i(full)
  );

  ssbp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(jv), .din_i(jin), .full_o(full),
    .pop_i(pop), .empty_o(empty), .dout_o(jout)
  );

  ssbp_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .job_i(jout), .pop_o(pop),
    .valid_o, .stall_i, .data_byte_o, .last_o
  );

endmodule

// ===== rtl/ssbp_front.sv =====
// ----------------------------------------------------------------------------
// ssbp_front
// accepts items, keeps the carried group and forms byte jobs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ssbp_front import ssbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        action_i,
  input  logic [16:0] sample_i,
  input  mode_e       mode_i,
  input  logic [9:0]  pad_i,
  output logic        job_valid_o,
  output job_t        job_o,
  input  logic        job_full_i
);

  logic [9:0] carried_q [3];
  logic [1:0] count_q, count_d;
  logic [9:0] v [4];
  logic [9:0] s10;
  logic       acc, grp;
  logic [29:0] w;
  logic [31:0] fbits;

  assign stall_o = job_full_i;
  assign acc     = valid_i && !job_full_i;
  assign s10     = sample_i[9:0];
  assign grp     = (mode_i == MODE_TEN45) || (mode_i == MODE_TRI32);
  assign fbits   = to_float(sample_i);

  always_comb begin
    for (int i = 0; i < 4; i++) v[i] = pad_i;
    if (action_i) begin
      for (int i = 0; i < 3; i++) if (2'(i) < count_q) v[i] = carried_q[i];
    end else begin
      v[0] = carried_q[0];
      v[1] = carried_q[1];
      v[2] = carried_q[2];
      if (mode_i == MODE_TEN45) v[3] = s10;
      else                      v[2] = s10;
    end
    w = {v[2], v[1], v[0]};
  end

  always_comb begin
    job_o       = '0;
    job_valid_o = 1'b0;
    count_d     = count_q;
    if (action_i) begin
      count_d = 2'd0;
      if (grp && count_q != 2'd0) job_valid_o = 1'b1;
    end else if (grp) begin
      if ({1'b0, count_q} + 3'd1 < ((mode_i == MODE_TEN45) ? 3'd4 : 3'd3)) begin
        count_d = count_q + 2'd1;
      end else begin
        count_d = 2'd0;
        job_valid_o = 1'b1;
      end
    end else if (mode_i != MODE_RSVD6 && mode_i != MODE_RSVD7) begin
      job_valid_o = 1'b1;
    end
    unique case (mode_i)
      MODE_TEN45: begin
        job_o.bytes = {v[0][9:2], v[0][1:0], v[1][9:4], v[1][3:0], v[2][9:6],
                       v[2][5:0], v[3][9:8], v[3][7:0]};
        job_o.count = 3'd5;
      end
      MODE_TRI32: begin
        job_o.count = 3'd4;
        job_o.bytes = {w[7:0], w[15:8], w[23:16], {2'b00, w[29:24]}, 8'd0};
      end
      MODE_BYTE: begin
        job_o.bytes = {sample_i[7:0], 32'd0};
        job_o.count = 3'd1;
      end
      MODE_LE16: begin
        job_o.bytes = {sample_i[7:0], sample_i[15:8], 24'd0};
        job_o.count = 3'd2;
      end
      MODE_BE16: begin
        job_o.bytes = {sample_i[15:8], sample_i[7:0], 24'd0};
        job_o.count = 3'd2;
      end
      MODE_FLOAT: begin
        job_o.bytes = {fbits[7:0], fbits[15:8], fbits[23:16], fbits[31:24], 8'd0};
        job_o.count = 3'd4;
      end
      default: begin
        job_o.count = 3'd0;
      end
    endcase
    if (!acc) job_valid_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else if (acc) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && !action_i && grp && count_d != 2'd0) begin
      carried_q[count_q] <= s10;
    end
  end

endmodule

// ===== rtl/ssbp_queue.sv =====
// ----------------------------------------------------------------------------
// ssbp_queue
// short job queue between front and back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ssbp_queue import ssbp_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t din_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t dout_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t          mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= din_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

endmodule

// ===== rtl/ssbp_back.sv =====
// ----------------------------------------------------------------------------
// ssbp_back
// sends the bytes of one job, one per transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ssbp_back import ssbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [7:0] data_byte_o,
  output logic       last_o
);

  logic [2:0] idx_q;
  logic       fire;

  assign valid_o     = !empty_i;
  assign fire        = valid_o && !stall_i;
  assign last_o      = (idx_q + 3'd1 == job_i.count);
  assign data_byte_o = job_i.bytes[39 - 8*idx_q -: 8];
  assign pop_o       = fire && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else if (fire) begin
      idx_q <= last_o ? 3'd0 : idx_q + 3'd1;
    end
  end

endmodule

// ===== rtl/ssbp_checker.sv =====
// ----------------------------------------------------------------------------
// ssbp_checker
// port-level checks for the sample byte packer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sample_stream_byte_packer_top_defines.svh"
module ssbp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       stall_o,
  input logic       valid_o,
  input logic       stall_i,
  input logic [7:0] data_byte_o,
  input logic       last_o
);

  `SSBP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, valid_o && stall_i, valid_o)
  `SSBP_ASSERT_NEXT(a_byte_hold, clk_i, rst_ni, valid_o && stall_i,
    $stable(data_byte_o) && $stable(last_o))
  `SSBP_ASSERT_IMPL(a_stall_busy, clk_i, rst_ni, stall_o, valid_o)

endmodule

bind sample_stream_byte_packer_top ssbp_checker u_ssbp_checker (
  .clk_i, .rst_ni, .stall_o, .valid_o, .stall_i, .data_byte_o, .last_o
);
